>>> rtl/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_TABLE_LEN   = 24;

   // Width of the product terms: Q4.28 values reach about +-2^32
   localparam int TERM_W = 34;
   // Width of the CORDIC datapath (x grows by the CORDIC gain, about 1.65)
   localparam int CORD_W = 36;
   // Square-root radicand: 2^56 - s^2, fits in 57 bits
   localparam int RAD_W  = 57;
   localparam int ROOT_W = 29;

   localparam logic signed [TERM_W-1:0] Q28_ONE = TERM_W'(64'sd268435456);
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // atan(2^-i), 2^32 units per turn
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // One vectoring rotation state
   typedef struct packed {
      logic signed [CORD_W-1:0] x;
      logic signed [CORD_W-1:0] y;
      logic [31:0]              ang;
      logic                     zero;
   } cord_type;

   // Per-item side data carried along the pipeline
   typedef struct packed {
      logic signed [TERM_W-1:0] sp;
      logic                     clamped;
   } side_type;

endpackage
`default_nettype wire

>>> rtl/q2e_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface q2e_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic               pitch_clamped;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/quaternion_to_euler_zyx.sv
`timescale 1ns / 1ps
`default_nettype none
// Quaternion (Q2.14) to ZYX Euler angles (16-bit binary angles, 32768 = pi).
// Fully pipelined: one quaternion accepted per cycle while the output is not
// stalled (products, sums and radicand in three stages, square root of 15
// stages with roll/yaw terms delayed alongside, atan2 of 1 + min(CORDIC_STEPS,
// atan table length) stages, rounding folded into the output register). The whole
// pipeline advances when the output register is free or taken; a stall holds
// every stage. Pitch saturates to +-16384 with pitch_clamped set when
// |2(wy - zx)| >= 1.0. No state besides the pipeline.
module quaternion_to_euler_zyx #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input wire     clock,
   input wire     reset,
   q2e_req_if.sink   req,
   q2e_rsp_if.source rsp
);
   localparam int N     = (CORDIC_STEPS > q2e_pkg::ATAN_TABLE_LEN) ?
                          q2e_pkg::ATAN_TABLE_LEN : CORDIC_STEPS;
   localparam int SQ_LAT = q2e_pkg::ROOT_W / 2 + 1;
   localparam int CD_LAT = N + 1;
   // stages ahead of the output register: prod(1) sum(1) sq(1) sqrt(SQ_LAT)
   // cordic(CD_LAT)
   localparam int LAT   = 3 + SQ_LAT + CD_LAT;
   localparam int TW    = q2e_pkg::TERM_W;
   localparam int CW    = q2e_pkg::CORD_W;

   logic adv;
   logic [LAT-1:0] vld_ff;
   logic rv_ff;

   // advance when the output slot is empty or being taken
   assign adv       = !rv_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rv_ff  <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
         rv_ff  <= vld_ff[LAT-1];
      end
   end

   // stage 1: nine products
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= req.quat_w * req.quat_x;
         yz_ff <= req.quat_y * req.quat_z;
         xx_ff <= req.quat_x * req.quat_x;
         yy_ff <= req.quat_y * req.quat_y;
         wy_ff <= req.quat_w * req.quat_y;
         zx_ff <= req.quat_z * req.quat_x;
         wz_ff <= req.quat_w * req.quat_z;
         xy_ff <= req.quat_x * req.quat_y;
         zz_ff <= req.quat_z * req.quat_z;
      end
   end

   // stage 2: ZYX terms in Q4.28
   logic signed [TW-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sr_ff <= (TW'(wx_ff) + TW'(yz_ff)) <<< 1;
         cr_ff <= q2e_pkg::Q28_ONE - ((TW'(xx_ff) + TW'(yy_ff)) <<< 1);
         sp_ff <= (TW'(wy_ff) - TW'(zx_ff)) <<< 1;
         sy_ff <= (TW'(wz_ff) + TW'(xy_ff)) <<< 1;
         cy_ff <= q2e_pkg::Q28_ONE - ((TW'(yy_ff) + TW'(zz_ff)) <<< 1);
      end
   end

   // stage 3: radicand 2^56 - sp^2 (split square: sp < 2^28 when used)
   logic clamp_c;
   logic [27:0] spm_c;
   logic [q2e_pkg::RAD_W-1:0] rad_ff;
   logic signed [TW-1:0] sp3_ff;
   logic clamp3_ff;
   logic signed [TW-1:0] sr3_ff, cr3_ff, sy3_ff, cy3_ff;
   always_comb begin
      logic signed [TW-1:0] mag;
      clamp_c = (sp_ff >= q2e_pkg::Q28_ONE) || (sp_ff <= -q2e_pkg::Q28_ONE);
      mag     = sp_ff[TW-1] ? -sp_ff : sp_ff;
      spm_c   = mag[27:0];
   end
   logic [13:0] lo_c, hi_c;
   logic [27:0] hh_c, hl_c, ll_c;
   assign lo_c = spm_c[13:0];
   assign hi_c = spm_c[27:14];
   assign hh_c = hi_c * hi_c;
   assign hl_c = hi_c * lo_c;
   assign ll_c = lo_c * lo_c;
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= (q2e_pkg::RAD_W'(1) << 56)
                 - ((q2e_pkg::RAD_W'(hh_c) << 28)
                 + (q2e_pkg::RAD_W'(hl_c) << 15)
                 + q2e_pkg::RAD_W'(ll_c));
         sp3_ff    <= sp_ff;
         clamp3_ff <= clamp_c;
         sr3_ff <= sr_ff;
         cr3_ff <= cr_ff;
         sy3_ff <= sy_ff;
         cy3_ff <= cy_ff;
      end
   end

   // square root stages, side data delayed alongside
   logic [q2e_pkg::ROOT_W-1:0] root;
   q2e_sqrt u_sqrt (.clock(clock), .adv(adv), .rad_in(rad_ff), .root_out(root));

   q2e_pkg::side_type side_d [0:SQ_LAT];
   logic signed [TW-1:0] srd [0:SQ_LAT], crd [0:SQ_LAT], syd [0:SQ_LAT], cyd [0:SQ_LAT];
   assign side_d[0] = '{sp: sp3_ff, clamped: clamp3_ff};
   assign srd[0] = sr3_ff;
   assign crd[0] = cr3_ff;
   assign syd[0] = sy3_ff;
   assign cyd[0] = cy3_ff;
   for (genvar k = 0; k < SQ_LAT; k++) begin : g_sqd
      q2e_pkg::side_type s_ff;
      logic signed [TW-1:0] a_ff, b_ff, c_ff, d_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff <= side_d[k];
            a_ff <= srd[k];
            b_ff <= crd[k];
            c_ff <= syd[k];
            d_ff <= cyd[k];
         end
      end
      assign side_d[k+1] = s_ff;
      assign srd[k+1] = a_ff;
      assign crd[k+1] = b_ff;
      assign syd[k+1] = c_ff;
      assign cyd[k+1] = d_ff;
   end

   // three atan2 pipelines in lockstep
   logic [31:0] ang_r, ang_p, ang_y;
   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock(clock), .adv(adv), .y_in(CW'(srd[SQ_LAT])), .x_in(CW'(crd[SQ_LAT])),
      .ang_out(ang_r));
   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .adv(adv), .y_in(CW'(side_d[SQ_LAT].sp)),
      .x_in(CW'({1'b0, root})), .ang_out(ang_p));
   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
      .clock(clock), .adv(adv), .y_in(CW'(syd[SQ_LAT])), .x_in(CW'(cyd[SQ_LAT])),
      .ang_out(ang_y));

   logic clmp_d [0:CD_LAT];
   logic sgn_d  [0:CD_LAT];
   assign clmp_d[0] = side_d[SQ_LAT].clamped;
   assign sgn_d[0]  = side_d[SQ_LAT].sp[TW-1];
   for (genvar k = 0; k < CD_LAT; k++) begin : g_cdd
      logic c_ff, s_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            c_ff <= clmp_d[k];
            s_ff <= sgn_d[k];
         end
      end
      assign clmp_d[k+1] = c_ff;
      assign sgn_d[k+1]  = s_ff;
   end

   // round to 16 bits, limit pitch, saturate on clamp
   logic [31:0] rr_c, ry_c;
   logic signed [16:0] pp_c;
   logic signed [15:0] pitch_c;
   always_comb begin
      logic [31:0] pa;
      rr_c = ang_r + 32'h8000;
      ry_c = ang_y + 32'h8000;
      pa   = ang_p + 32'h8000;
      pp_c = $signed({ang_p[31], pa[31:16]});
      if (ang_p[31] && !pa[31]) pp_c = 17'sd0;
      if (clmp_d[CD_LAT])
         pitch_c = sgn_d[CD_LAT] ? -16'sd16384 : 16'sd16384;
      else if (pp_c > 17'sd16384)
         pitch_c = 16'sd16384;
      else if (pp_c < -17'sd16384)
         pitch_c = -16'sd16384;
      else
         pitch_c = pp_c[15:0];
   end

   logic signed [15:0] roll_ff, pitch_ff, yaw_ff;
   logic clamped_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff    <= rr_c[31:16];
         pitch_ff   <= pitch_c;
         yaw_ff     <= ry_c[31:16];
         clamped_ff <= clmp_d[CD_LAT];
      end
   end

   assign rsp.valid         = rv_ff;
   assign rsp.roll_angle    = roll_ff;
   assign rsp.pitch_angle   = pitch_ff;
   assign rsp.yaw_angle     = yaw_ff;
   assign rsp.pitch_clamped = clamped_ff;
endmodule
`default_nettype wire

>>> rtl/q2e_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// One registered CORDIC vectoring iteration with shift STEP
module q2e_cordic_stage #(
   parameter int STEP = 0
) (
   input  wire                  clock,
   input  wire                  adv,
   input  q2e_pkg::cord_type    d_in,
   output q2e_pkg::cord_type    d_out
);
   q2e_pkg::cord_type s_ff, s_in;
   logic signed [q2e_pkg::CORD_W-1:0] xs, ys;

   // rotate toward the x axis
   always_comb begin
      xs = d_in.x >>> STEP;
      ys = d_in.y >>> STEP;
      s_in = d_in;
      if (!d_in.y[q2e_pkg::CORD_W-1]) begin
         s_in.x   = d_in.x + ys;
         s_in.y   = d_in.y - xs;
         s_in.ang = d_in.ang + q2e_pkg::atan_entry(5'(STEP));
      end else begin
         s_in.x   = d_in.x - ys;
         s_in.y   = d_in.y + xs;
         s_in.ang = d_in.ang - q2e_pkg::atan_entry(5'(STEP));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) s_ff <= s_in;
   end
   assign d_out = s_ff;
endmodule
`default_nettype wire

>>> rtl/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined atan2: pre-rotation stage, then one stage per iteration
module q2e_cordic #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input  wire                               clock,
   input  wire                               adv,
   input  wire signed [q2e_pkg::CORD_W-1:0]  y_in,
   input  wire signed [q2e_pkg::CORD_W-1:0]  x_in,
   output logic [31:0]                       ang_out
);
   localparam int N = (CORDIC_STEPS > q2e_pkg::ATAN_TABLE_LEN) ?
                      q2e_pkg::ATAN_TABLE_LEN : CORDIC_STEPS;

   q2e_pkg::cord_type pre_ff, pre_in;
   q2e_pkg::cord_type chain [0:N];

   // fold left half-plane, flag zero vector
   always_comb begin
      pre_in.zero = (x_in == '0) && (y_in == '0);
      if (x_in[q2e_pkg::CORD_W-1]) begin
         pre_in.x   = -x_in;
         pre_in.y   = -y_in;
         pre_in.ang = q2e_pkg::HALF_TURN;
      end else begin
         pre_in.x   = x_in;
         pre_in.y   = y_in;
         pre_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) pre_ff <= pre_in;
   end
   assign chain[0] = pre_ff;

   for (genvar i = 0; i < N; i++) begin : g_stage
      q2e_cordic_stage #(.STEP(i)) u_stage (
         .clock (clock),
         .adv   (adv),
         .d_in  (chain[i]),
         .d_out (chain[i+1])
      );
   end

   assign ang_out = chain[N].zero ? 32'd0 : chain[N].ang;
endmodule
`default_nettype wire

>>> rtl/q2e_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined floor square root, two result bits per stage
module q2e_sqrt (
   input  wire                             clock,
   input  wire                             adv,
   input  wire  [q2e_pkg::RAD_W-1:0]       rad_in,
   output logic [q2e_pkg::ROOT_W-1:0]      root_out
);
   localparam int NBITS = 2 * q2e_pkg::ROOT_W;   // 58-bit radicand window
   localparam int NST   = q2e_pkg::ROOT_W / 2 + 1;
   localparam int PER   = 2;

   logic [NBITS-1:0]          rem  [0:NST];
   logic [q2e_pkg::ROOT_W-1:0] root [0:NST];
   logic [NBITS-1:0]          rad  [0:NST];

   assign rem[0]  = '0;
   assign root[0] = '0;
   assign rad[0]  = NBITS'(rad_in);

   // restoring digit recurrence, bits from the top pair down
   for (genvar s = 0; s < NST; s++) begin : g_st
      logic [NBITS-1:0]           r_ff, d_ff, r_c, d_c;
      logic [q2e_pkg::ROOT_W-1:0] q_ff, q_c;
      always_comb begin
         logic [NBITS-1:0] trial;
         r_c = rem[s];
         q_c = root[s];
         d_c = rad[s];
         for (int k = 0; k < PER; k++) begin
            if (s * PER + k < q2e_pkg::ROOT_W) begin
               r_c   = {r_c[NBITS-3:0], d_c[NBITS-1:NBITS-2]};
               d_c   = {d_c[NBITS-3:0], 2'b00};
               trial = {q_c[q2e_pkg::ROOT_W-2:0], 2'b01};
               if (r_c >= trial) begin
                  r_c = r_c - trial;
                  q_c = {q_c[q2e_pkg::ROOT_W-2:0], 1'b1};
               end else begin
                  q_c = {q_c[q2e_pkg::ROOT_W-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff <= r_c;
            q_ff <= q_c;
            d_ff <= d_c;
         end
      end
      assign rem[s+1]  = r_ff;
      assign root[s+1] = q_ff;
      assign rad[s+1]  = d_ff;
   end

   assign root_out = root[NST];
endmodule
`default_nettype wire
